### rtl/rcpwd_pkg.sv
// ----------------------------------------------------------------------------
// rcpwd_pkg
// Shared constants and types for the RC servo pulse width decoder.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

    // Number of decoded channels
    localparam int CHANNELS = 8;
    // Channel memory address width
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int CHIDX_W = 3;
    localparam int TIME_W  = 16;
    localparam int WIDTH_W = 16;

    // Stream bus widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = ((CHIDX_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WIDTH_W + 7) / 8) * 8;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_WIDTH = 1'b0;
    localparam logic CFG_MAX_WIDTH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'h0000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'hFFFF;

    typedef logic [CH_AW-1:0] t_addr;

    // One channel memory word
    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_width;
        logic [TIME_W-1:0]  last_edge;
    } t_entry;

endpackage

### rtl/rc_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder
// Multi-channel RC servo pulse width decoder with per-channel aging marks.
// ----------------------------------------------------------------------------
// Each channel's last edge time and pulse width live in a small synchronous
// memory with a registered read port. A capture edge reads the memory when it
// is accepted, then computes the modulo-65536 difference and writes back in
// ST_EDGE; a read waits in ST_READ until the output register is empty or
// i_m_axis_tready frees it; a period tick or an unused item kind is handled
// without leaving ST_IDLE, since the fresh and valid marks sit in flip-flops
// and all age at once. After reset the memory needs no clearing pass: a
// per-channel written bit makes an untouched channel read its last edge time
// as zero.
module rc_pulse_width_decoder
    import rcpwd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: [2:0] channel_index, [18:3] edge_time, rest zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: [1:0] func
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,
    // Result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: [15:0] width_out
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: [0] width_valid
    output logic                 o_m_axis_tuser,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [WIDTH_W-1:0]   i_cfg_data
);

    // FSM codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EDGE = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [WIDTH_W-1:0]  r_min_width, r_max_width;
    logic [CHIDX_W-1:0]  r_ch;
    logic                r_ch_ok;
    logic [TIME_W-1:0]   r_time;
    logic [CHANNELS-1:0] r_written, n_written;
    logic [CHANNELS-1:0] r_fresh, n_fresh;
    logic [CHANNELS-1:0] r_valid, n_valid;
    logic                r_out_valid;
    logic [WIDTH_W-1:0]  r_out_width;
    logic                r_out_flag;

    t_entry              mem [CHANNELS];
    t_entry              r_rdata;

    logic                s_accept;
    logic [FUNC_W-1:0]   s_func;
    logic [CHIDX_W-1:0]  s_ch;
    logic [TIME_W-1:0]   s_time;
    logic                s_ch_ok;
    logic                rd_en;
    logic                wr_en;
    t_entry              wr_data;
    t_addr               r_addr;
    logic [TIME_W-1:0]   prev_edge;
    logic [WIDTH_W-1:0]  diff;
    logic                in_window;
    logic                out_load;

    // Input field unpacking
    assign s_func  = i_s_axis_tuser;
    assign s_ch    = i_s_axis_tdata[CHIDX_W-1:0];
    assign s_time  = i_s_axis_tdata[CHIDX_W+TIME_W-1:CHIDX_W];
    assign s_ch_ok = (32'(s_ch) < CHANNELS);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign r_addr          = t_addr'(r_ch);

    // Memory read issued with the accepted transaction
    assign rd_en = s_accept && ((s_func == FUNC_EDGE) || (s_func == FUNC_READ));

    // Edge arithmetic on the word read back
    assign prev_edge = r_written[r_addr] ? r_rdata.last_edge : '0;
    assign diff      = r_time - prev_edge;
    assign in_window = (diff > r_min_width) && (diff < r_max_width);

    assign wr_en                = (r_state == ST_EDGE) && r_ch_ok;
    assign wr_data.last_edge    = r_time;
    assign wr_data.pulse_width  = in_window ? diff : r_rdata.pulse_width;

    assign out_load = (r_state == ST_READ) && (!r_out_valid || i_m_axis_tready);

    // Channel memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[t_addr'(s_ch)];
        end
    end

    // Next state and mark updates
    always_comb begin
        n_state   = r_state;
        n_written = r_written;
        n_fresh   = r_fresh;
        n_valid   = r_valid;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_func)
                        FUNC_EDGE: n_state = ST_EDGE;
                        FUNC_READ: n_state = ST_READ;
                        FUNC_TICK: begin
                            // Age every channel at once
                            n_valid = r_valid & r_fresh;
                            n_fresh = '0;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE: begin
                if (r_ch_ok) begin
                    n_written[r_addr] = 1'b1;
                    if (in_window) begin
                        n_fresh[r_addr] = 1'b1;
                        n_valid[r_addr] = 1'b1;
                    end
                end
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_written   <= '0;
            r_fresh     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_min_width <= MIN_WIDTH_RST;
            r_max_width <= MAX_WIDTH_RST;
        end else begin
            r_state   <= n_state;
            r_written <= n_written;
            r_fresh   <= n_fresh;
            r_valid   <= n_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_WIDTH: r_min_width <= i_cfg_data;
                    CFG_MAX_WIDTH: r_max_width <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ch    <= s_ch;
            r_ch_ok <= s_ch_ok;
            r_time  <= s_time;
        end
        if (out_load) begin
            if (r_ch_ok && r_valid[r_addr]) begin
                r_out_width <= r_rdata.pulse_width;
                r_out_flag  <= 1'b1;
            end else begin
                r_out_width <= '0;
                r_out_flag  <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_width);
    assign o_m_axis_tuser  = r_out_flag;

endmodule

### rtl/rcpwd_checker.sv
// ----------------------------------------------------------------------------
// rcpwd_checker
// Port-level assertions for the RC servo pulse width decoder.
// ----------------------------------------------------------------------------
module rcpwd_checker
    import rcpwd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [FUNC_W-1:0]    i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tuser
);

    // Stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // An invalid channel always reads as zero width
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero width without valid flag");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // After an accepted edge or read transaction, input ready is low in the cycle after
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
        (i_s_axis_tuser == FUNC_EDGE || i_s_axis_tuser == FUNC_READ)
            |=> !o_s_axis_tready)
        else $error("ready right after edge or read");

endmodule

bind rc_pulse_width_decoder rcpwd_checker u_rcpwd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC servo pulse width decoder. Capture edges,
// period ticks, reads and unused kinds go in on the input stream. A predictor
// class keeps its own copy of the per-channel state and the width window. Each
// read result is checked against the oldest expected read. Both sides of the
// stream stall at random, and the window is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpwd_pkg::*;

    // Unused item kind, not listed in the package
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 200;
    localparam int TAIL_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 8;

    // Expected contents of one read transaction
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic               valid;
    } t_read_result;

    // ------------------------------------------------------------------------
    // Predictor: per-channel edge time, width and aging marks
    // ------------------------------------------------------------------------
    class width_scoreboard;
        logic [WIDTH_W-1:0] lo_bound;
        logic [WIDTH_W-1:0] hi_bound;
        logic [TIME_W-1:0]  prev_edge [CHANNELS];
        logic [WIDTH_W-1:0] held_width [CHANNELS];
        bit                 is_fresh [CHANNELS];
        bit                 is_valid [CHANNELS];
        t_read_result       reads_due [$];
        int                 n_edges;
        int                 n_caught;
        int                 n_ticks;
        int                 n_reads;
        int                 n_checked;

        function new();
            lo_bound  = MIN_WIDTH_RST;
            hi_bound  = MAX_WIDTH_RST;
            n_edges   = 0;
            n_caught  = 0;
            n_ticks   = 0;
            n_reads   = 0;
            n_checked = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                prev_edge[i]  = '0;
                held_width[i] = '0;
                is_fresh[i]   = 1'b0;
                is_valid[i]   = 1'b0;
            end
        endfunction

        function void set_reg(logic idx, logic [WIDTH_W-1:0] value);
            if (idx == CFG_MIN_WIDTH) lo_bound = value;
            else hi_bound = value;
        endfunction

        // Note one accepted input transaction
        function void note_item(logic [FUNC_W-1:0] func, logic [CHIDX_W-1:0] ch,
                                logic [TIME_W-1:0] t);
            logic [WIDTH_W-1:0] diff;
            t_read_result       res;
            case (func)
                FUNC_EDGE: begin
                    n_edges++;
                    if (int'(ch) < CHANNELS) begin
                        diff = t - prev_edge[ch];
                        if (diff > lo_bound && diff < hi_bound) begin
                            held_width[ch] = diff;
                            is_valid[ch]   = 1'b1;
                            is_fresh[ch]   = 1'b1;
                            n_caught++;
                        end
                        prev_edge[ch] = t;
                    end
                end
                FUNC_TICK: begin
                    n_ticks++;
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (is_fresh[i]) is_fresh[i] = 1'b0;
                        else is_valid[i] = 1'b0;
                    end
                end
                FUNC_READ: begin
                    n_reads++;
                    if (int'(ch) < CHANNELS && is_valid[ch]) begin
                        res.width = held_width[ch];
                        res.valid = 1'b1;
                    end else begin
                        res.width = '0;
                        res.valid = 1'b0;
                    end
                    reads_due.push_back(res);
                end
                default: begin
                    // unused kind: no effect
                end
            endcase
        endfunction

        // Compare one result transaction with the oldest expected read
        function bit check_result(logic [WIDTH_W-1:0] width, logic valid,
                                  output string msg);
            t_read_result exp_res;
            msg = "";
            if (reads_due.size() == 0) begin
                msg = $sformatf("unexpected result width=%0d valid=%0b", width, valid);
                return 1'b0;
            end
            exp_res = reads_due.pop_front();
            n_checked++;
            if (width !== exp_res.width)
                msg = $sformatf("width_out %0d, expected %0d", width, exp_res.width);
            if (valid !== exp_res.valid)
                msg = {msg, $sformatf(" width_valid %0b, expected %0b", valid, exp_res.valid)};
            return msg == "";
        endfunction

        function int pending();
            return reads_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic [FUNC_W-1:0]    s_user  = '0;
    logic                 m_ready = 1'b0;
    logic                 cfg_we  = 1'b0;
    logic                 cfg_idx = 1'b0;
    logic [WIDTH_W-1:0]   cfg_data = '0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    width_scoreboard sb;
    int  errors       = 0;
    int  holds_asked  = 0;
    int  holds_served = 0;
    bit  quiet_tail   = 1'b0;
    int  gap_pct      = 0;
    logic [WIDTH_W-1:0] win_lo = MIN_WIDTH_RST;
    logic [WIDTH_W-1:0] win_hi = MAX_WIDTH_RST;
    logic [TIME_W-1:0]  stim_edge [CHANNELS];

    rc_pulse_width_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: [2:0] channel_index, [18:3] edge_time, rest zero
        .i_s_axis_tdata  (s_data),
        // tuser: [1:0] func
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // tdata: [15:0] width_out
        .o_m_axis_tdata  (o_m_axis_tdata),
        // tuser: [0] width_valid
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #3ms;
        $display("timeout: %0d reads still outstanding", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        errors++;
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        string msg;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (!sb.check_result(o_m_axis_tdata[WIDTH_W-1:0], o_m_axis_tuser, msg))
                report_mismatch(msg);
        end
    end

    // Result ready: random stalls, long hold-off on request, none in the tail
    initial begin
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (holds_served != holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CHIDX_W-1:0] ch,
                             input logic [TIME_W-1:0] t);
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= S_TDATA_W'({t, ch});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_item(func, ch, t);
        if (func == FUNC_EDGE) stim_edge[ch] = t;
    endtask

    task automatic idle_input(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait until every read has come back and the last edge has settled
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable afterwards
    task automatic write_reg(input logic idx, input logic [WIDTH_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        if (idx == CFG_MIN_WIDTH) win_lo = value;
        else win_hi = value;
    endtask

    task automatic set_window(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
        drain_block();
        write_reg(CFG_MIN_WIDTH, lo);
        write_reg(CFG_MAX_WIDTH, hi);
        cfg_we <= 1'b0;
    endtask

    // Pulse length for the next edge: mostly inside the window, some at its
    // borders, some anywhere
    function automatic logic [WIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && {1'b0, win_hi} > {1'b0, win_lo} + 17'd1)
            return WIDTH_W'($urandom_range(int'(win_lo) + 1, int'(win_hi) - 1));
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return win_lo;
                1: return win_lo + 16'd1;
                2: return win_hi - 16'd1;
                default: return win_hi;
            endcase
        end
        return WIDTH_W'($urandom);
    endfunction

    task automatic random_item();
        int                 r;
        logic [CHIDX_W-1:0] ch;
        r  = $urandom_range(0, 99);
        ch = CHIDX_W'($urandom_range(0, CHANNELS - 1));
        if (r < 62) send_item(FUNC_EDGE, ch, stim_edge[ch] + pick_width());
        else if (r < 72) send_item(FUNC_TICK, CHIDX_W'($urandom), TIME_W'($urandom));
        else if (r < 97) send_item(FUNC_READ, ch, TIME_W'($urandom));
        else send_item(FUNC_UNUSED, CHIDX_W'($urandom), TIME_W'($urandom));
    endtask

    task automatic random_phase(input int items);
        for (int n = 0; n < items; n++) begin
            if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
                idle_input($urandom_range(1, 12));
            random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [WIDTH_W-1:0] lo_set [8];
        logic [WIDTH_W-1:0] hi_set [8];
        int                 gaps [3];

        sb = new();
        for (int i = 0; i < CHANNELS; i++) stim_edge[i] = '0;
        lo_set = '{16'd900, 16'd0, 16'hFFFF, 16'd0, 16'd1000, 16'hFFFE, 16'd0, 16'd0};
        hi_set = '{16'd2100, 16'hFFFF, 16'd0, 16'd2, 16'd1001, 16'hFFFF, 16'd0, 16'd0};
        lo_set[6] = WIDTH_W'($urandom_range(0, 4000));
        hi_set[6] = lo_set[6] + WIDTH_W'($urandom_range(2, 30000));
        lo_set[7] = WIDTH_W'($urandom);
        hi_set[7] = WIDTH_W'($urandom);
        gaps = '{0, 10, 35};

        // reset
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset window, zero difference, wrap, upper limit, aging
        send_item(FUNC_READ, 3'd0, 16'h0000);
        send_item(FUNC_EDGE, 3'd0, 16'h0000);
        send_item(FUNC_EDGE, 3'd0, 16'd1000);
        send_item(FUNC_READ, 3'd0, 16'hFFFF);
        send_item(FUNC_EDGE, 3'd7, 16'hFFFF);
        send_item(FUNC_EDGE, 3'd7, 16'h0010);
        send_item(FUNC_READ, 3'd7, 16'h0000);
        send_item(FUNC_UNUSED, 3'd7, 16'hFFFF);
        send_item(FUNC_READ, 3'd7, 16'h0000);
        send_item(FUNC_TICK, 3'd0, 16'h0000);
        send_item(FUNC_READ, 3'd0, 16'h0000);
        send_item(FUNC_TICK, 3'd7, 16'hFFFF);
        send_item(FUNC_READ, 3'd0, 16'h0000);
        send_item(FUNC_EDGE, 3'd3, 16'h8000);
        send_item(FUNC_READ, 3'd3, 16'h0000);
        send_item(FUNC_READ, 3'd5, 16'h0000);

        // directed: empty window, then borders of a narrow window
        set_window(16'd100, 16'd101);
        send_item(FUNC_EDGE, 3'd1, 16'd5000);
        send_item(FUNC_EDGE, 3'd1, 16'd5100);
        send_item(FUNC_EDGE, 3'd1, 16'd5201);
        send_item(FUNC_READ, 3'd1, 16'h0000);
        set_window(16'd100, 16'd200);
        send_item(FUNC_EDGE, 3'd2, 16'd100);
        send_item(FUNC_EDGE, 3'd2, 16'd300);
        send_item(FUNC_READ, 3'd2, 16'h0000);
        send_item(FUNC_EDGE, 3'd2, 16'd401);
        send_item(FUNC_READ, 3'd2, 16'h0000);
        send_item(FUNC_EDGE, 3'd2, 16'd600);
        send_item(FUNC_READ, 3'd2, 16'h0000);

        // random phases over several windows
        for (int p = 0; p < 8; p++) begin
            set_window(lo_set[p], hi_set[p]);
            gap_pct = gaps[$urandom_range(0, 2)];
            if (p == 1) begin
                // back-pressure: reads pile up behind a stalled receiver
                holds_asked++;
                for (int n = 0; n < 40; n++)
                    send_item(FUNC_READ, CHIDX_W'($urandom_range(0, CHANNELS - 1)), '0);
            end
            random_phase(PHASE_ITEMS);
        end

        // tail without idling on either side
        set_window(16'd500, 16'd3000);
        quiet_tail = 1'b1;
        random_phase(TAIL_ITEMS);

        // wind down
        drain_block();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d expected reads never arrived", sb.pending()));
        $display("covered %0d edges (%0d widths taken), %0d ticks, %0d reads checked",
                 sb.n_edges, sb.n_caught, sb.n_ticks, sb.n_checked);
        $display("over 12 window settings incl. empty and full-range windows; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
